// File: rtl/trs_matrix_builder_assert.svh
// Assertion macros for the transform matrix builder.
`ifndef TRS_MATRIX_BUILDER_ASSERT_SVH
`define TRS_MATRIX_BUILDER_ASSERT_SVH
// Assert that an implication holds at every clock edge outside reset.
`define TRS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Assert that an implication holds in the next cycle.
`define TRS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: rtl/trs_pkg.sv
// Shared constants, types and functions for the transform matrix builder.
package trs_pkg;
  localparam int CordicSteps = 24;
  localparam int FullTurn = 23040;
  localparam int QuarterTurn = 5760;
  localparam int PipeDepth = 11;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic signed [33:0] OneQ30 = 34'sd1073741824;

  typedef logic signed [33:0] q30_t;
  typedef logic signed [31:0] word_t;
  typedef logic signed [15:0] scale_t;

  // Quadrant codes.
  typedef enum logic [1:0] {QUAD0 = 2'd0, QUAD1 = 2'd1, QUAD2 = 2'd2, QUAD3 = 2'd3} quad_t;

  // One CORDIC lane: vector, residual angle and quadrant.
  typedef struct packed {
    q30_t x;
    q30_t y;
    logic signed [36:0] z;
    quad_t q;
  } cordic_t;

  function automatic logic signed [36:0] atan_of(input int i);
    logic signed [36:0] r;
    r = '0;
    case (i)
      0: r = 37'sd188743680;
      1: r = 37'sd111421900;
      2: r = 37'sd58872272;
      3: r = 37'sd29884485;
      4: r = 37'sd15000234;
      5: r = 37'sd7507429;
      6: r = 37'sd3754631;
      7: r = 37'sd1877430;
      8: r = 37'sd938729;
      9: r = 37'sd469366;
      10: r = 37'sd234683;
      11: r = 37'sd117342;
      12: r = 37'sd58671;
      13: r = 37'sd29335;
      14: r = 37'sd14668;
      15: r = 37'sd7334;
      16: r = 37'sd3667;
      17: r = 37'sd1833;
      18: r = 37'sd917;
      19: r = 37'sd458;
      20: r = 37'sd229;
      21: r = 37'sd115;
      22: r = 37'sd57;
      23: r = 37'sd29;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Q30 times Q30, rounded half up back to Q30.
  function automatic q30_t mul30(input q30_t a, input q30_t b);
    logic signed [67:0] p;
    p = 68'(a) * 68'(b) + (68'sd1 <<< 29);
    return q30_t'(p >>> 30);
  endfunction

  // Q30 times Q4.12 to Q8.24, saturated.
  function automatic word_t scale_sat(input q30_t e, input scale_t k);
    logic signed [51:0] p;
    logic signed [51:0] v;
    word_t r;
    p = 52'(e) * 52'(k) + (52'sd1 <<< 17);
    v = p >>> 18;
    if (v > 52'sd2147483647) r = 32'sh7fffffff;
    else if (v < -52'sd2147483648) r = 32'sh80000000;
    else r = word_t'(v);
    return r;
  endfunction
endpackage

// File: rtl/trs_matrix_builder.sv
// Top level: pipelined T*Rz*Ry*Rx*S matrix composer.
// One transform enters per clock when nothing stalls; its matrix passes the stages
// below in order to the outputs and is taken while out_stall is low. The pipeline
// holds an angle-reduction stage, six CORDIC stages of four
// micro-rotations each (three lanes in parallel), a quadrant map, two product
// stages and one scale stage. Stall from the output freezes the whole pipe;
// a stage with no valid item is refilled even under stall, so bubbles close.
module trs_matrix_builder (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [31:0] trans_x, input logic signed [31:0] trans_y,
  input  logic signed [31:0] trans_z,
  input  logic signed [17:0] angle_x, input logic signed [17:0] angle_y,
  input  logic signed [17:0] angle_z,
  input  logic signed [15:0] scale_x, input logic signed [15:0] scale_y,
  input  logic signed [15:0] scale_z,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [31:0] m_r0c0, output logic signed [31:0] m_r1c0,
  output logic signed [31:0] m_r2c0, output logic signed [31:0] m_r0c1,
  output logic signed [31:0] m_r1c1, output logic signed [31:0] m_r2c1,
  output logic signed [31:0] m_r0c2, output logic signed [31:0] m_r1c2,
  output logic signed [31:0] m_r2c2, output logic signed [31:0] m_r0c3,
  output logic signed [31:0] m_r1c3, output logic signed [31:0] m_r2c3
);
  import trs_pkg::*;

  typedef struct packed {
    word_t tx; word_t ty; word_t tz;
    scale_t kx; scale_t ky; scale_t kz;
  } side_t;

  logic [PipeDepth-1:0] vld;
  logic [PipeDepth-1:0] en;
  side_t side [PipeDepth-1];
  cordic_t red [3];
  cordic_t lanes [7][3];
  q30_t cx, sx, cy, sy, cz, sz;
  q30_t trig [6];
  q30_t p1 [8];
  q30_t p2 [9];
  word_t res [12];

  // Stage i loads when it is empty or the stage after it moves.
  always_comb begin
    en[PipeDepth-1] = !vld[PipeDepth-1] || !out_stall;
    for (int i = PipeDepth - 2; i >= 0; i--) en[i] = !vld[i] || en[i+1];
  end
  assign in_stall = !en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int i = 1; i < PipeDepth; i++) if (en[i]) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) side[0] <= '{trans_x, trans_y, trans_z, scale_x, scale_y, scale_z};
    for (int i = 1; i < PipeDepth - 1; i++) if (en[i]) side[i] <= side[i-1];
  end

  trs_angle_reduce u_rx (.angle(angle_x), .lane(red[0]));
  trs_angle_reduce u_ry (.angle(angle_y), .lane(red[1]));
  trs_angle_reduce u_rz (.angle(angle_z), .lane(red[2]));

  always_ff @(posedge clk) begin
    if (en[0]) lanes[0] <= red;
  end

  for (genvar g = 0; g < 6; g++) begin : g_cordic
    trs_cordic_stage u_stage (
      .clk(clk), .en(en[g+1]), .base(5'(4 * g)),
      .lin(lanes[g]), .lout(lanes[g+1])
    );
  end

  function automatic q30_t clamp1(input q30_t v);
    q30_t r;
    if (v > OneQ30) r = OneQ30;
    else if (v < -OneQ30) r = -OneQ30;
    else r = v;
    return r;
  endfunction

  // Quadrant map, lane 0 = x, 1 = y, 2 = z; stage 7.
  always_ff @(posedge clk) begin
    if (en[7]) begin
      for (int l = 0; l < 3; l++) begin
        automatic q30_t c = clamp1(lanes[6][l].x);
        automatic q30_t s = clamp1(lanes[6][l].y);
        unique case (lanes[6][l].q)
          QUAD0: begin trig[2*l] <= c; trig[2*l+1] <= s; end
          QUAD1: begin trig[2*l] <= -s; trig[2*l+1] <= c; end
          QUAD2: begin trig[2*l] <= -c; trig[2*l+1] <= -s; end
          QUAD3: begin trig[2*l] <= s; trig[2*l+1] <= -c; end
          default: begin trig[2*l] <= c; trig[2*l+1] <= s; end
        endcase
      end
    end
  end
  assign cx = trig[0]; assign sx = trig[1];
  assign cy = trig[2]; assign sy = trig[3];
  assign cz = trig[4]; assign sz = trig[5];

  // First products; stage 8.
  always_ff @(posedge clk) begin
    if (en[8]) begin
      p1[0] <= mul30(sy, sx);
      p1[1] <= mul30(sy, cx);
      p1[2] <= mul30(cz, cy);
      p1[3] <= mul30(sz, cy);
      p1[4] <= -sy;
      p1[5] <= mul30(cy, sx);
      p1[6] <= mul30(cy, cx);
      p1[7] <= cz;
    end
  end

  // Second products, carried sz/cx/sx are taken from a delayed copy; stage 9.
  q30_t d_sz, d_cx, d_sx;
  always_ff @(posedge clk) begin
    if (en[8]) begin d_sz <= sz; d_cx <= cx; d_sx <= sx; end
  end
  always_ff @(posedge clk) begin
    if (en[9]) begin
      p2[0] <= p1[2];
      p2[1] <= p1[3];
      p2[2] <= p1[4];
      p2[3] <= mul30(p1[7], p1[0]) - mul30(d_sz, d_cx);
      p2[4] <= mul30(d_sz, p1[0]) + mul30(p1[7], d_cx);
      p2[5] <= p1[5];
      p2[6] <= mul30(p1[7], p1[1]) + mul30(d_sz, d_sx);
      p2[7] <= mul30(d_sz, p1[1]) - mul30(p1[7], d_sx);
      p2[8] <= p1[6];
    end
  end

  // Scale and saturate the rotation entries, pass the translation; stage 10 is the output register.
  always_ff @(posedge clk) begin
    if (en[10]) begin
      for (int e = 0; e < 9; e++) begin
        automatic scale_t k = (e < 3) ? side[9].kx : ((e < 6) ? side[9].ky : side[9].kz);
        res[e] <= scale_sat(p2[e], k);
      end
      res[9] <= side[9].tx;
      res[10] <= side[9].ty;
      res[11] <= side[9].tz;
    end
  end

  assign out_valid = vld[PipeDepth-1];
  assign m_r0c0 = res[0]; assign m_r1c0 = res[1]; assign m_r2c0 = res[2];
  assign m_r0c1 = res[3]; assign m_r1c1 = res[4]; assign m_r2c1 = res[5];
  assign m_r0c2 = res[6]; assign m_r1c2 = res[7]; assign m_r2c2 = res[8];
  assign m_r0c3 = res[9]; assign m_r1c3 = res[10]; assign m_r2c3 = res[11];
endmodule

// File: rtl/trs_angle_reduce.sv
// Angle reduction: modulo a full turn, quadrant split, CORDIC start vector.
module trs_angle_reduce (
  input  logic signed [17:0] angle,
  output trs_pkg::cordic_t   lane
);
  import trs_pkg::*;
  logic signed [19:0] a0;
  logic [17:0] a;
  logic [17:0] r;
  // 18 bit angle spans under 6 turns each way: fold with a few compares.
  always_comb begin
    a0 = 20'(angle);
    for (int k = 0; k < 3; k++) begin
      if (a0 < 0) a0 = a0 + 20'(FullTurn) * 20'sd4;
    end
    for (int k = 0; k < 3; k++) begin
      if (a0 >= 20'(FullTurn) * 20'sd2) a0 = a0 - 20'(FullTurn) * 20'sd2;
    end
    if (a0 >= 20'(FullTurn)) a0 = a0 - 20'(FullTurn);
    a = 18'(a0);
    if (a >= 18'(3 * QuarterTurn)) begin
      lane.q = QUAD3; r = a - 18'(3 * QuarterTurn);
    end else if (a >= 18'(2 * QuarterTurn)) begin
      lane.q = QUAD2; r = a - 18'(2 * QuarterTurn);
    end else if (a >= 18'(QuarterTurn)) begin
      lane.q = QUAD1; r = a - 18'(QuarterTurn);
    end else begin
      lane.q = QUAD0; r = a;
    end
    lane.x = CordicGain;
    lane.y = '0;
    lane.z = 37'({19'd0, r}) <<< 16;
  end
endmodule

// File: rtl/trs_cordic_stage.sv
// Four CORDIC micro-rotations for three angle lanes, one register stage.
module trs_cordic_stage (
  input  logic                clk,
  input  logic                en,
  input  logic [4:0]          base,
  input  trs_pkg::cordic_t    lin [3],
  output trs_pkg::cordic_t    lout [3]
);
  import trs_pkg::*;
  cordic_t nxt [3];
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      nxt[l] = lin[l];
      for (int s = 0; s < 4; s++) begin
        automatic q30_t dx = nxt[l].y >>> (int'(base) + s);
        automatic q30_t dy = nxt[l].x >>> (int'(base) + s);
        if (nxt[l].z >= 0) begin
          nxt[l].x = nxt[l].x - dx;
          nxt[l].y = nxt[l].y + dy;
          nxt[l].z = nxt[l].z - atan_of(int'(base) + s);
        end else begin
          nxt[l].x = nxt[l].x + dx;
          nxt[l].y = nxt[l].y - dy;
          nxt[l].z = nxt[l].z + atan_of(int'(base) + s);
        end
      end
    end
  end
  always_ff @(posedge clk) begin
    if (en) lout <= nxt;
  end
endmodule

// File: rtl/trs_checker.sv
// Port-level checker for the transform matrix builder, bound to the top.
`include "trs_matrix_builder_assert.svh"
module trs_checker (
  input logic clk,
  input logic rst,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic signed [31:0] m_r0c3
);
  `TRS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(m_r0c3))
  `TRS_ASSERT_IMP(a_no_stall_when_drain, !out_valid, !in_stall)
  `TRS_ASSERT_NEXT(a_reset_empty, $past(rst), !out_valid)
endmodule

bind trs_matrix_builder trs_checker u_trs_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .m_r0c3(m_r0c3)
);
